// ----- src/mwc_pkg.sv -----
package mwc_pkg;

  localparam int TEXT_DEPTH_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MAX_PATTERN_DEF   = 15;

  localparam int REQ_W    = 2;
  localparam int LETTER_W = 5;
  localparam int START_W  = 10;
  localparam int LEN_W    = 11;

  // request codes on the req_type port
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PATTERN  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = 2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    logic                alpha;
    logic                last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_BEST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               ovf;
  } result_t;

endpackage

// ----- src/mwc_front.sv -----
module mwc_front import mwc_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_text,
  output logic                full,
  input  logic                take,
  output logic                q_valid,
  output item_t               q_item
);

  item_t          q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           enq;
  logic           deq;
  item_t          dec;

  always_comb begin
    dec        = '0;
    dec.letter = letter;
    dec.alpha  = 32'(letter) < ALPHABET_SIZE;
    unique case (req_type)
      REQ_CLEAR:   dec.op = OP_CLEAR;
      REQ_PATTERN: dec.op = OP_PATTERN;
      REQ_TEXT: begin
        dec.op   = OP_TEXT;
        dec.last = last_text;
      end
      default:     dec.op = OP_CLEAR;
    endcase
  end

  assign full    = count == (QAW+1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_item  = q[rd_ptr];
  // reserved request codes are taken and dropped here
  assign enq     = push && !full && req_type != REQ_RESERVED;
  assign deq     = take && q_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(enq) - (QAW+1)'(deq);
    end
  end

endmodule

// ----- src/mwc_back.sv -----
module mwc_back import mwc_pkg::*; #(
  parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    take,
  output logic    out_valid,
  output result_t res,
  input  logic    pop
);

  localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PW = $clog2(TEXT_DEPTH + 1);
  localparam int NW = $clog2(MAX_PATTERN + 1);
  localparam int LW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  state_t state;
  state_t state_next;

  logic [LETTER_W-1:0] mem [TEXT_DEPTH];
  logic [LETTER_W-1:0] rdata;

  logic [NW-1:0] need [ALPHABET_SIZE];
  logic [PW-1:0] have [ALPHABET_SIZE];

  logic [PW-1:0] text_pos;
  logic [AW-1:0] cur_pos;
  logic [AW-1:0] wb;
  logic [NW-1:0] covered;
  logic [NW-1:0] plen;
  logic [AW-1:0] best_start;
  logic [PW-1:0] best_len;
  logic          ovf;
  logic          last_r;

  logic [LW-1:0] idx;
  logic [NW-1:0] need_rd;
  logic [PW-1:0] have_rd;
  logic [PW-1:0] have_inc;
  logic [NW-1:0] cov_inc;
  logic          text_full;
  logic          counted;
  logic          cover_hit;
  logic          rd_alpha;
  logic          surplus;
  logic          drop;
  logic [PW-1:0] win_len;
  logic          idle_item;

  assign idle_item = state == ST_IDLE && q_valid;
  assign take      = idle_item;

  // single count port: the stored letter while shrinking, else the incoming one
  assign idx     = (state == ST_CHK) ? LW'(rdata) : LW'(q_item.letter);
  assign need_rd = need[idx];
  assign have_rd = have[idx];

  assign text_full = 32'(text_pos) >= TEXT_DEPTH;
  assign counted   = q_item.alpha && need_rd != '0;
  assign have_inc  = have_rd + 1'b1;
  assign cov_inc   = (32'(have_inc) <= 32'(need_rd)) ? covered + 1'b1 : covered;
  assign cover_hit = cov_inc == plen;

  assign rd_alpha = 32'(rdata) < ALPHABET_SIZE;
  assign surplus  = 32'(have_rd) > 32'(need_rd);
  assign drop     = !rd_alpha || have_rd == '0 || surplus;

  assign win_len = PW'(cur_pos) - PW'(wb) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_TEXT) begin
          if (!text_full && counted && cover_hit) begin
            state_next = ST_RD;
          end else if (q_item.last) begin
            state_next = ST_OUT;
          end
        end
      end
      ST_RD:   state_next = (wb < cur_pos) ? ST_CHK : ST_BEST;
      ST_CHK:  state_next = drop ? ST_RD : ST_BEST;
      ST_BEST: state_next = last_r ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (!out_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (idle_item && q_item.op == OP_TEXT && !text_full) begin
      mem[text_pos[AW-1:0]] <= q_item.letter;
    end
    rdata <= mem[wb];
  end

  always_ff @(posedge clk) begin
    if (rst || (idle_item && q_item.op == OP_CLEAR)) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        need[i] <= '0;
        have[i] <= '0;
      end
      text_pos   <= '0;
      wb         <= '0;
      covered    <= '0;
      plen       <= '0;
      best_start <= '0;
      best_len   <= '0;
      ovf        <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.op == OP_PATTERN) begin
            if (text_pos == '0 && q_item.alpha) begin
              if (32'(plen) >= MAX_PATTERN) begin
                ovf <= 1'b1;
              end else begin
                need[idx] <= need_rd + 1'b1;
                plen      <= plen + 1'b1;
              end
            end
          end else if (q_valid && q_item.op == OP_TEXT) begin
            if (text_full) begin
              ovf <= 1'b1;
            end else begin
              text_pos <= text_pos + 1'b1;
              if (counted) begin
                have[idx] <= have_inc;
                covered   <= cov_inc;
              end
            end
          end
        end
        ST_CHK: begin
          if (drop) begin
            if (rd_alpha && surplus) begin
              have[idx] <= have_rd - 1'b1;
            end
            wb <= wb + 1'b1;
          end
        end
        ST_BEST: begin
          if (best_len == '0 || win_len < best_len) begin
            best_start <= wb;
            best_len   <= win_len;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (idle_item && q_item.op == OP_TEXT) begin
      cur_pos <= text_pos[AW-1:0];
      last_r  <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && !out_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && !out_valid) begin
      res.found <= best_len != '0;
      res.start <= (best_len != '0) ? START_W'(best_start) : '0;
      res.len   <= LEN_W'(best_len);
      res.ovf   <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_wb_in_text: assert property (@(posedge clk) disable iff (rst)
    PW'(wb) <= text_pos)
    else $error("window start beyond stored text");

  a_cov_bound: assert property (@(posedge clk) disable iff (rst)
    covered <= plen)
    else $error("covered count exceeds pattern length");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    best_len <= text_pos)
    else $error("best window longer than text");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> state == ST_IDLE)
    else $error("item taken while busy");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded");
`endif

endmodule

// ----- src/minimum_window_cover.sv -----
// Minimum window cover: shortest text window holding every pattern letter.
// Clear, pattern and text items are taken in the sequencer's idle state; a letter
// that completes a cover steps the window start through read and check states, then
// records the best window. The result is loaded after the last letter, once the previous one is popped.
// The sequencer takes no new item until it is back in idle; a 4-item queue decouples input.
// Synchronous reset clears counts, positions, flags and the item queue.
module minimum_window_cover import mwc_pkg::*; #(
  parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_text,
  output logic                empty,
  input  logic                pop,
  output logic                found,
  output logic [START_W-1:0]  window_start,
  output logic [LEN_W-1:0]    window_len,
  output logic                overflow
);

  logic    take;
  logic    q_valid;
  item_t   q_item;
  logic    out_valid;
  result_t res;

  mwc_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req_type (req_type),
    .letter   (letter),
    .last_text(last_text),
    .full     (full),
    .take     (take),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  mwc_back #(
    .TEXT_DEPTH   (TEXT_DEPTH),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .MAX_PATTERN  (MAX_PATTERN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .take     (take),
    .out_valid(out_valid),
    .res      (res),
    .pop      (pop)
  );

  assign empty        = !out_valid;
  assign found        = res.found;
  assign window_start = res.start;
  assign window_len   = res.len;
  assign overflow     = res.ovf;

endmodule

// ----- tb/minimum_window_cover_tb.sv -----
module minimum_window_cover_tb;
  import mwc_pkg::*;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [LETTER_W-1:0] ch;
    logic                lst;
    logic                drain;
    logic                hold_rx;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  logic                full;
  logic [REQ_W-1:0]    req_type;
  logic [LETTER_W-1:0] letter;
  logic                last_text;
  logic                empty;
  logic                pop;
  logic                found;
  logic [START_W-1:0]  window_start;
  logic [LEN_W-1:0]    window_len;
  logic                overflow;

  minimum_window_cover dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .letter       (letter),
    .last_text    (last_text),
    .empty        (empty),
    .pop          (pop),
    .found        (found),
    .window_start (window_start),
    .window_len   (window_len),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t       stim_q[$];
  result_t     cover_due[$];
  int unsigned n_total;
  int unsigned n_accepted = 0;
  int unsigned n_fail = 0;
  int unsigned cyc = 0;
  logic        hold_kick;
  int unsigned hold_left;

  // predictor state for the current query
  int unsigned    need_tally[ALPHABET_SIZE_DEF];
  int unsigned    have_tally[ALPHABET_SIZE_DEF];
  logic [LETTER_W-1:0] text_mem[TEXT_DEPTH_DEF];
  int unsigned    text_at, win_lo, covered, pat_len, best_lo, best_width;
  logic           ovf_seen;

  wire quiet = (cyc >= 2000) && (cyc < 3500);

  always @(posedge clk) cyc <= cyc + 1;

  function automatic void restart_query();
    for (int i = 0; i < ALPHABET_SIZE_DEF; i++) begin
      need_tally[i] = 0;
      have_tally[i] = 0;
    end
    text_at    = 0;
    win_lo     = 0;
    covered    = 0;
    pat_len    = 0;
    best_lo    = 0;
    best_width = 0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void predict_cover(input logic [REQ_W-1:0] rq,
                                        input logic [LETTER_W-1:0] c,
                                        input logic lst);
    int unsigned p, b, ln;
    result_t     r;
    case (rq)
      REQ_CLEAR: restart_query();
      REQ_PATTERN: begin
        if (text_at == 0 && c < ALPHABET_SIZE_DEF) begin
          if (pat_len >= MAX_PATTERN_DEF) begin
            ovf_seen = 1'b1;
          end else begin
            need_tally[c]++;
            pat_len++;
          end
        end
      end
      REQ_TEXT: begin
        if (text_at >= TEXT_DEPTH_DEF) begin
          ovf_seen = 1'b1;
        end else begin
          p = text_at;
          text_mem[p] = c;
          text_at = p + 1;
          if (c < ALPHABET_SIZE_DEF && need_tally[c] != 0) begin
            have_tally[c]++;
            if (have_tally[c] <= need_tally[c]) covered++;
            if (covered == pat_len) begin
              // slide the left edge past spare or unneeded letters
              while (win_lo < p) begin
                b = text_mem[win_lo];
                if (b < ALPHABET_SIZE_DEF && have_tally[b] != 0 &&
                    have_tally[b] <= need_tally[b]) break;
                if (b < ALPHABET_SIZE_DEF && have_tally[b] > need_tally[b])
                  have_tally[b]--;
                win_lo++;
              end
              ln = p - win_lo + 1;
              if (best_width == 0 || ln < best_width) begin
                best_lo    = win_lo;
                best_width = ln;
              end
            end
          end
        end
        if (lst) begin
          r.found = (best_width != 0);
          r.start = (best_width != 0) ? best_lo[START_W-1:0] : '0;
          r.len   = best_width[LEN_W-1:0];
          r.ovf   = ovf_seen;
          cover_due = {cover_due, r};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic queue_item(input int rq, input int c, input int lst);
    stim_t s;
    s.req     = rq[REQ_W-1:0];
    s.ch      = c[LETTER_W-1:0];
    s.lst     = lst[0];
    s.drain   = 1'b0;
    s.hold_rx = 1'b0;
    stim_q = {stim_q, s};
  endtask

  task automatic random_query();
    int span, base, plen, tlen, c;
    span = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE_DEF : $urandom_range(1, 5);
    base = $urandom_range(0, ALPHABET_SIZE_DEF - span);
    case ($urandom_range(0, 9))
      0:       plen = 0;
      1:       plen = $urandom_range(14, 18);
      default: plen = $urandom_range(1, 4);
    endcase
    tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    queue_item(REQ_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1));
    for (int i = 0; i < plen; i++)
      queue_item(REQ_PATTERN, base + $urandom_range(0, span - 1), $urandom_range(0, 1));
    for (int i = 0; i < tlen; i++) begin
      if ($urandom_range(0, 29) == 0)
        queue_item(REQ_PATTERN, $urandom_range(0, 31), $urandom_range(0, 1));
      if ($urandom_range(0, 29) == 0)
        queue_item(REQ_RESERVED, $urandom_range(0, 31), $urandom_range(0, 1));
      c = ($urandom_range(0, 19) == 0) ? $urandom_range(ALPHABET_SIZE_DEF, 31)
                                       : base + $urandom_range(0, span - 1);
      queue_item(REQ_TEXT, c, i == tlen - 1);
    end
  endtask

  // sender
  always @(posedge clk) begin : drive_items
    stim_t s;
    bit    take;
    if (rst) begin
      push      <= 1'b0;
      req_type  <= REQ_CLEAR;
      letter    <= '0;
      last_text <= 1'b0;
      hold_kick <= 1'b0;
      restart_query();
    end else begin
      if (push && !full) begin
        predict_cover(req_type, letter, last_text);
        n_accepted++;
      end
      if (push && full) begin
        hold_kick <= 1'b0;
      end else begin
        take = (stim_q.size() != 0) && (quiet || $urandom_range(0, 99) >= 24);
        if (take && stim_q[0].drain && cover_due.size() != 0) take = 1'b0;
        if (take) begin
          s = stim_q.pop_front();
          req_type  <= s.req;
          letter    <= s.ch;
          last_text <= s.lst;
        end
        push      <= take;
        hold_kick <= take && s.hold_rx;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch_results
    result_t e;
    if (rst) begin
      pop       <= 1'b0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (cover_due.size() == 0) begin
          $error("result with no item expected");
          n_fail++;
        end else begin
          e = cover_due.pop_front();
          if (found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, found);
            n_fail++;
          end
          if (window_start !== e.start) begin
            $error("window_start: expected %0d, got %0d", e.start, window_start);
            n_fail++;
          end
          if (window_len !== e.len) begin
            $error("window_len: expected %0d, got %0d", e.len, window_len);
            n_fail++;
          end
          if (overflow !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, overflow);
            n_fail++;
          end
        end
      end
      if (hold_kick)
        hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
      pop <= !hold_kick && hold_left == 0 && (quiet || $urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    int base_n;
    rst = 1'b1;

    // empty pattern straight after reset
    queue_item(REQ_TEXT, 0, 1);
    // ignored items, out-of-alphabet letters, late pattern letter, surplus drop, tie
    queue_item(REQ_CLEAR, 0, 1);
    queue_item(REQ_RESERVED, 31, 1);
    queue_item(REQ_PATTERN, 31, 0);
    queue_item(REQ_PATTERN, 25, 0);
    queue_item(REQ_PATTERN, 0, 0);
    queue_item(REQ_TEXT, 0, 0);
    queue_item(REQ_TEXT, 30, 0);
    queue_item(REQ_PATTERN, 1, 1);
    queue_item(REQ_TEXT, 25, 0);
    queue_item(REQ_TEXT, 0, 0);
    queue_item(REQ_TEXT, 25, 1);
    // pattern too long
    queue_item(REQ_CLEAR, 0, 0);
    repeat (16) queue_item(REQ_PATTERN, 1, 0);
    queue_item(REQ_TEXT, 1, 1);

    // text fills the store; window at the very end, then two letters dropped
    queue_item(REQ_CLEAR, 0, 0);
    queue_item(REQ_PATTERN, 25, 0);
    repeat (TEXT_DEPTH_DEF - 1) queue_item(REQ_TEXT, 0, 0);
    queue_item(REQ_TEXT, 25, 0);
    queue_item(REQ_TEXT, 16, 0);
    queue_item(REQ_TEXT, 16, 1);
    // window spans the whole store
    queue_item(REQ_CLEAR, 0, 0);
    queue_item(REQ_PATTERN, 0, 0);
    queue_item(REQ_PATTERN, 25, 0);
    queue_item(REQ_TEXT, 0, 0);
    repeat (TEXT_DEPTH_DEF - 2) queue_item(REQ_TEXT, 12, 0);
    queue_item(REQ_TEXT, 25, 1);

    base_n = stim_q.size();
    while (stim_q.size() < base_n + 350) begin
      if ($urandom_range(0, 99) < 85)
        random_query();
      else
        queue_item($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 1));
    end
    // wait for the result queue to drain, then hold the receiver off under a burst
    queue_item(REQ_CLEAR, 0, 0);
    stim_q[stim_q.size() - 1].drain   = 1'b1;
    stim_q[stim_q.size() - 1].hold_rx = 1'b1;
    queue_item(REQ_PATTERN, 3, 0);
    queue_item(REQ_TEXT, 3, 1);
    repeat (30) begin
      queue_item(REQ_CLEAR, 0, 0);
      queue_item(REQ_PATTERN, $urandom_range(0, 25), 0);
      queue_item(REQ_TEXT, $urandom_range(0, 25), 1);
    end
    while (stim_q.size() < base_n + 700) begin
      if ($urandom_range(0, 99) < 85)
        random_query();
      else
        queue_item($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 1));
    end
    n_total = stim_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (cover_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
